FILE: rtl/ics_pkg.sv
// Shared types and constants of the inverse CDF square-root sampler.
`timescale 1ns / 1ps
`default_nettype none
package ics_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned LvlIdxW    = 10;
  localparam int unsigned BrdIdxW    = 11;
  localparam int unsigned LvlW       = 25;
  localparam int unsigned RootW      = 28;
  localparam int unsigned SqSteps    = 28;
  localparam int unsigned DivSteps   = 63;

  localparam logic [LvlW-1:0] LevelOne = 25'h100_0000;

  localparam logic [1:0] OpWrLevel  = 2'd0;
  localparam logic [1:0] OpWrBorder = 2'd1;
  localparam logic [1:0] OpDraw     = 2'd2;

  localparam logic [1:0] SqSelY1 = 2'd0;
  localparam logic [1:0] SqSelY2 = 2'd1;
  localparam logic [1:0] SqSelP  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH1,
    S_FETCH2,
    S_FETCH3,
    S_EVAL,
    S_SQRT,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_FINISH
  } ics_state_e;

  typedef struct packed {
    logic       wr_lvl;
    logic       wr_brd;
    logic       load;
    logic       scan;
    logic       fetch1;
    logic       fetch2;
    logic       fetch3;
    logic       eval;
    logic       sq_start;
    logic [1:0] sq_sel;
    logic       mul;
    logic       div_start;
    logic       finish;
  } ics_cmd_t;

  typedef struct packed {
    logic hit;
    logic flat;
    logic sq_done;
    logic den_pos;
    logic div_done;
  } ics_stat_t;

endpackage
`default_nettype wire

FILE: rtl/ics_ctrl.sv
// Controller state machine that sequences the sampler datapath.
`timescale 1ns / 1ps
`default_nettype none
module ics_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [1:0]       cmd_i,
  input  wire ics_pkg::ics_stat_t stat_i,
  output ics_pkg::ics_cmd_t     cmd_o,
  output logic                  busy_o
);

  ics_pkg::ics_state_e state_q, state_d;
  logic [1:0] sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ics_pkg::S_IDLE;
      sel_q   <= ics_pkg::SqSelY1;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    unique case (state_q)
      ics_pkg::S_IDLE: begin
        if (start_i) begin
          if (cmd_i == ics_pkg::OpWrLevel) begin
            cmd_o.wr_lvl = 1'b1;
          end else if (cmd_i == ics_pkg::OpWrBorder) begin
            cmd_o.wr_brd = 1'b1;
          end else if (cmd_i == ics_pkg::OpDraw) begin
            cmd_o.load = 1'b1;
            state_d    = ics_pkg::S_SCAN;
          end
        end
      end
      ics_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) state_d = ics_pkg::S_FETCH1;
      end
      ics_pkg::S_FETCH1: begin
        cmd_o.fetch1 = 1'b1;
        state_d      = ics_pkg::S_FETCH2;
      end
      ics_pkg::S_FETCH2: begin
        cmd_o.fetch2 = 1'b1;
        state_d      = ics_pkg::S_FETCH3;
      end
      ics_pkg::S_FETCH3: begin
        cmd_o.fetch3 = 1'b1;
        state_d      = ics_pkg::S_EVAL;
      end
      ics_pkg::S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.flat) begin
          state_d = ics_pkg::S_FINISH;
        end else begin
          cmd_o.sq_start = 1'b1;
          cmd_o.sq_sel   = ics_pkg::SqSelY1;
          sel_d          = ics_pkg::SqSelY1;
          state_d        = ics_pkg::S_SQRT;
        end
      end
      ics_pkg::S_SQRT: begin
        if (stat_i.sq_done) begin
          if (sel_q == ics_pkg::SqSelP) begin
            state_d = ics_pkg::S_MUL;
          end else begin
            cmd_o.sq_start = 1'b1;
            cmd_o.sq_sel   = sel_q + 2'd1;
            sel_d          = sel_q + 2'd1;
          end
        end
      end
      ics_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = stat_i.den_pos ? ics_pkg::S_DIVGO : ics_pkg::S_FINISH;
      end
      ics_pkg::S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ics_pkg::S_DIV;
      end
      ics_pkg::S_DIV: begin
        if (stat_i.div_done) state_d = ics_pkg::S_FINISH;
      end
      ics_pkg::S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ics_pkg::S_IDLE;
      end
      default: state_d = ics_pkg::S_IDLE;
    endcase
  end

  assign busy_o = (state_q != ics_pkg::S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/ics_dp.sv
// Datapath: level and border tables, scan compare, square-root unit, multiplier, divider.
`timescale 1ns / 1ps
`default_nettype none
module ics_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ics_pkg::ics_cmd_t    cmd_i,
  output ics_pkg::ics_stat_t        stat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [10:0]          cfg_wdata_i,
  input  wire logic [10:0]          entry_index_i,
  input  wire logic signed [31:0]   entry_value_i,
  input  wire logic [24:0]          probability_i,
  output logic signed [31:0]        sample_value_o,
  output logic [9:0]                bin_found_o,
  output logic                      flat_bin_o,
  output logic                      done_o
);

  // Tables
  logic [ics_pkg::LvlW-1:0] lvl_mem [ics_pkg::TableDepth];
  logic [31:0]              brd_mem [ics_pkg::TableDepth+1];
  logic [ics_pkg::LvlW-1:0] lvl_rd_q;
  logic [31:0]              brd_rd_q;
  logic [ics_pkg::LvlIdxW-1:0] lvl_addr;
  logic [ics_pkg::BrdIdxW-1:0] brd_addr;
  logic lvl_we, brd_we;

  logic [10:0] bins_q;
  logic [10:0] n_q;
  logic [24:0] p_q;
  logic [ics_pkg::LvlIdxW-1:0] scan_idx_q, cmp_idx_q, k_q, n1, n2;
  logic cmp_vld_q;
  logic merge;
  logic [24:0] y1_q, y2_q;
  logic signed [31:0] x1_q, x2_q;
  logic flat_q;

  // Square-root unit
  logic [55:0] sq_rad_q;
  logic [30:0] sq_rem_q, sq_rem_n, sq_diff;
  logic [29:0] sq_trial;
  logic [ics_pkg::RootW-1:0] sq_root_q, sq_root_n;
  logic [4:0]  sq_cnt_q;
  logic        sq_busy_q;
  logic [1:0]  sq_sel_q;
  logic [24:0] sq_src;
  logic [ics_pkg::RootW-1:0] s1_q, s2_q, s_q;

  // Multiply and divide
  logic signed [32:0] d_diff;
  logic signed [28:0] e_diff;
  logic signed [61:0] prod_q;
  logic [61:0] mag;
  logic [27:0] den;
  logic [62:0] div_num_q;
  logic [28:0] div_rem_q;
  logic [29:0] div_rem_n;
  logic        div_ge;
  logic [5:0]  div_cnt_q;
  logic        div_busy_q;
  logic        neg_q;
  logic signed [65:0] x_sum;
  logic signed [31:0] x_sat;

  assign n1    = ics_pkg::LvlIdxW'(n_q - 11'd1);
  assign n2    = ics_pkg::LvlIdxW'(n_q - 11'd2);
  assign merge = (k_q != '0) && (k_q == n2);

  assign lvl_we = cmd_i.wr_lvl && (entry_index_i < 11'(ics_pkg::TableDepth));
  assign brd_we = cmd_i.wr_brd && (entry_index_i <= 11'(ics_pkg::TableDepth));

  always_comb begin
    if (cmd_i.fetch1) begin
      lvl_addr = k_q - 10'd1;
    end else if (cmd_i.fetch2) begin
      lvl_addr = k_q;
    end else begin
      lvl_addr = scan_idx_q;
    end
    if (cmd_i.fetch2) begin
      brd_addr = merge ? n_q : ({1'b0, k_q} + 11'd1);
    end else begin
      brd_addr = {1'b0, k_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) lvl_mem[entry_index_i[ics_pkg::LvlIdxW-1:0]] <= entry_value_i[24:0];
    lvl_rd_q <= lvl_mem[lvl_addr];
  end

  always_ff @(posedge clk_i) begin
    if (brd_we) brd_mem[entry_index_i] <= entry_value_i;
    brd_rd_q <= brd_mem[brd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= 11'(ics_pkg::TableDepth);
    end else if (cfg_we_i) begin
      bins_q <= cfg_wdata_i;
    end
  end

  // Scan compare; the last level in use always counts as a hit.
  assign stat_o.hit = cmp_vld_q && ((cmp_idx_q == n1) || (lvl_rd_q > p_q));
  assign stat_o.flat = (y2_q <= y1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.scan) begin
      cmp_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q        <= probability_i;
      scan_idx_q <= '0;
      if (bins_q < 11'd2) begin
        n_q <= 11'd2;
      end else if (bins_q > 11'(ics_pkg::TableDepth)) begin
        n_q <= 11'(ics_pkg::TableDepth);
      end else begin
        n_q <= bins_q;
      end
    end
    if (cmd_i.scan) begin
      scan_idx_q <= scan_idx_q + 10'd1;
      cmp_idx_q  <= scan_idx_q;
      if (stat_o.hit) k_q <= cmp_idx_q;
    end
    if (cmd_i.fetch2) begin
      y1_q <= (k_q == '0) ? '0 : lvl_rd_q;
      x1_q <= brd_rd_q;
    end
    if (cmd_i.fetch3) begin
      y2_q <= ((k_q == n1) || merge) ? ics_pkg::LevelOne : lvl_rd_q;
      x2_q <= brd_rd_q;
    end
    if (cmd_i.eval) flat_q <= stat_o.flat;
    if (cmd_i.mul) begin
      flat_q <= !stat_o.den_pos;
      prod_q <= d_diff * e_diff;
    end
  end

  // Digit-by-digit square root, two radicand bits per cycle.
  always_comb begin
    unique case (cmd_i.sq_sel)
      ics_pkg::SqSelY1: sq_src = y1_q;
      ics_pkg::SqSelY2: sq_src = y2_q;
      default:          sq_src = p_q;
    endcase
    sq_rem_n = {sq_rem_q[28:0], sq_rad_q[55:54]};
    sq_trial = {sq_root_q, 2'b01};
    sq_diff  = sq_rem_n - {1'b0, sq_trial};
    if (sq_rem_n >= {1'b0, sq_trial}) begin
      sq_root_n = {sq_root_q[ics_pkg::RootW-2:0], 1'b1};
    end else begin
      sq_root_n = {sq_root_q[ics_pkg::RootW-2:0], 1'b0};
    end
  end

  assign stat_o.sq_done = sq_busy_q && (sq_cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
    end else if (cmd_i.sq_start) begin
      sq_busy_q <= 1'b1;
    end else if (stat_o.sq_done) begin
      sq_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_busy_q) begin
      sq_rad_q  <= {sq_rad_q[53:0], 2'b00};
      sq_rem_q  <= (sq_rem_n >= {1'b0, sq_trial}) ? sq_diff : sq_rem_n;
      sq_root_q <= sq_root_n;
      sq_cnt_q  <= sq_cnt_q - 5'd1;
      if (sq_cnt_q == '0) begin
        unique case (sq_sel_q)
          ics_pkg::SqSelY1: s1_q <= sq_root_n;
          ics_pkg::SqSelY2: s2_q <= sq_root_n;
          default:          s_q  <= sq_root_n;
        endcase
      end
    end
    if (cmd_i.sq_start) begin
      sq_rad_q  <= {1'b0, sq_src, 30'd0};
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_cnt_q  <= 5'(ics_pkg::SqSteps - 1);
      sq_sel_q  <= cmd_i.sq_sel;
    end
  end

  // Multiply operands and the rounding divider.
  assign d_diff         = {x2_q[31], x2_q} - {x1_q[31], x1_q};
  assign e_diff         = {1'b0, s_q} - {1'b0, s1_q};
  assign den            = s2_q - s1_q;
  assign stat_o.den_pos = (s2_q > s1_q);
  assign mag            = prod_q[61] ? 62'(-prod_q) : 62'(prod_q);

  assign div_rem_n = {div_rem_q, div_num_q[62]};
  assign div_ge    = (div_rem_n >= {2'b00, den});
  assign stat_o.div_done = div_busy_q && (div_cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
    end else if (stat_o.div_done) begin
      div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_num_q <= {1'b0, mag} + 63'(den >> 1);
      div_rem_q <= '0;
      div_cnt_q <= 6'(ics_pkg::DivSteps - 1);
      neg_q     <= prod_q[61];
    end else if (div_busy_q) begin
      div_rem_q <= div_ge ? 29'(div_rem_n - {2'b00, den}) : div_rem_n[28:0];
      div_num_q <= {div_num_q[61:0], div_ge};
      div_cnt_q <= div_cnt_q - 6'd1;
    end
  end

  always_comb begin
    if (neg_q) begin
      x_sum = 66'(x1_q) - $signed({3'b000, div_num_q});
    end else begin
      x_sum = 66'(x1_q) + $signed({3'b000, div_num_q});
    end
    if (x_sum > 66'sd2147483647) begin
      x_sat = 32'sh7FFF_FFFF;
    end else if (x_sum < -66'sd2147483648) begin
      x_sat = 32'sh8000_0000;
    end else begin
      x_sat = x_sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sample_value_o <= flat_q ? x1_q : x_sat;
      bin_found_o    <= k_q;
      flat_bin_o     <= flat_q;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/inverse_cdf_sqrt_sampler.sv
// Top level of the inverse CDF sampler with square-root interpolation.
//
// A command word is taken when start is high and busy is low. Command 0
// writes a cumulative level, command 1 a bin border; both finish in the
// accepting cycle and give no result. Command 3 is dropped. Command 2 draws
// a sample: the block scans the levels in use for the first one above the
// probability, reads the bin's levels and borders, takes three square roots
// on one shared unit, multiplies once and runs a restoring divider. A flat
// bin skips the roots and the divider. Throughput is one draw at a time, set
// by the level scan and the iterative root and divider; busy drops in the
// cycle the result is on the ports, so the next word can be taken at the
// edge that ends it. The result word is on the result ports for one cycle
// with done_o high; the receiver cannot stall it. The user must write the
// bins_in_use register through cfg_we_i/cfg_wdata_i only while idle; the
// block itself does not enforce it. Reset returns the controller to idle
// and sets bins_in_use to 1024; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module inverse_cdf_sqrt_sampler (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [10:0]        entry_index_i,
  input  wire logic signed [31:0] entry_value_i,
  input  wire logic [24:0]        probability_i,
  input  wire logic               cfg_we_i,
  input  wire logic [10:0]        cfg_wdata_i,
  output logic                    done_o,
  output logic signed [31:0]      sample_value_o,
  output logic [9:0]              bin_found_o,
  output logic                    flat_bin_o
);

  ics_pkg::ics_cmd_t  cmd;
  ics_pkg::ics_stat_t stat;

  ics_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  ics_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .probability_i (probability_i),
    .sample_value_o(sample_value_o),
    .bin_found_o   (bin_found_o),
    .flat_bin_o    (flat_bin_o),
    .done_o        (done_o)
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the inverse CDF sampler: random commands checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned OneQ24 = 16777216;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [10:0] idx;
    logic [31:0] val;
    logic [24:0] prob;
  } word_t;

  typedef struct packed {
    logic [31:0] value;
    logic [9:0]  bin;
    logic        flat;
  } draw_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd_i = '0;
  logic [10:0] entry_index_i = '0;
  logic signed [31:0] entry_value_i = '0;
  logic [24:0] probability_i = '0;
  logic cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic done_o;
  logic signed [31:0] sample_value_o;
  logic [9:0] bin_found_o;
  logic flat_bin_o;

  inverse_cdf_sqrt_sampler i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .entry_index_i, .entry_value_i,
    .probability_i, .cfg_we_i, .cfg_wdata_i, .done_o, .sample_value_o,
    .bin_found_o, .flat_bin_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  word_t pending_q[$];
  draw_t draws_q[$];
  bit [24:0] level_m[ics_pkg::TableDepth];
  bit [31:0] border_m[ics_pkg::TableDepth + 1];
  int unsigned bins_m = 1024;
  int unsigned n_errors = 0, n_words = 0, n_draws = 0, n_flat = 0;
  bit no_gaps = 1'b0;
  word_t cur;
  int gap = 0;

  function automatic longint unsigned root_of(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned level_of(int unsigned i, int unsigned n);
    return (i == n - 1) ? OneQ24 : level_m[i];
  endfunction

  function automatic draw_t predict_draw(logic [24:0] p);
    int unsigned n, k;
    longint unsigned y1, y2, mag, q;
    longint x1, x2, x, s1, s2, s, den, num;
    draw_t d;
    n = (bins_m < 2) ? 2 : (bins_m > ics_pkg::TableDepth) ? ics_pkg::TableDepth : bins_m;
    k = n - 1;
    for (int unsigned i = 0; i < n; i++) begin
      if (level_of(i, n) > p) begin
        k = i;
        break;
      end
    end
    y1 = (k == 0) ? 0 : level_of(k - 1, n);
    y2 = level_of(k, n);
    x1 = longint'($signed(border_m[k]));
    x2 = longint'($signed(border_m[k + 1]));
    // The last two bins are merged into one.
    if (k != 0 && k == n - 2) begin
      x2 = longint'($signed(border_m[n]));
      y2 = OneQ24;
    end
    d.flat = (y2 <= y1);
    x = x1;
    if (!d.flat) begin
      s1 = root_of(y1 << 30);
      s2 = root_of(y2 << 30);
      s = root_of(longint'(p) << 30);
      den = s2 - s1;
      if (den <= 0) begin
        d.flat = 1'b1;
      end else begin
        num = (x2 - x1) * (s - s1);
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        x = (num < 0) ? x1 - longint'(q) : x1 + longint'(q);
      end
    end
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    d.value = x[31:0];
    d.bin = k[9:0];
    return d;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %0s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Driver: updates the predictor when a word is taken, then offers the next.
  always @(posedge clk_i) begin
    word_t nxt;
    bit go;
    if (rst_ni) begin
      go = 1'b0;
      if (start && !busy) begin
        n_words++;
        case (cur.cmd)
          ics_pkg::OpWrLevel:
            if (cur.idx < ics_pkg::TableDepth) level_m[cur.idx[9:0]] = cur.val[24:0];
          ics_pkg::OpWrBorder:
            if (cur.idx <= ics_pkg::TableDepth) border_m[cur.idx] = cur.val;
          ics_pkg::OpDraw: draws_q.insert(draws_q.size(), predict_draw(cur.prob));
          default: ;
        endcase
        if (!no_gaps && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
      end
      if (!(start && busy)) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          cur = nxt;
          go = 1'b1;
          cmd_i <= nxt.cmd;
          entry_index_i <= nxt.idx;
          entry_value_i <= nxt.val;
          probability_i <= nxt.prob;
        end
        start <= go;
      end
    end
  end

  // Monitor: results cannot be held off, so each strobe is checked at once.
  always @(posedge clk_i) begin
    draw_t want;
    if (rst_ni && done_o) begin
      if (draws_q.size() == 0) begin
        report("unexpected word", sample_value_o, 0);
      end else begin
        want = draws_q.pop_front();
        n_draws++;
        if (want.flat) n_flat++;
        if (sample_value_o !== want.value) report("sample_value", sample_value_o, want.value);
        if (bin_found_o !== want.bin) report("bin_found", bin_found_o, want.bin);
        if (flat_bin_o !== want.flat) report("flat_bin", flat_bin_o, want.flat);
      end
    end
  end

  function automatic void push_word(logic [1:0] c, int unsigned i, logic [31:0] v,
                                    logic [24:0] p);
    word_t w;
    w.cmd = c;
    w.idx = i[10:0];
    w.val = v;
    w.prob = p;
    pending_q.insert(pending_q.size(), w);
  endfunction

  // Loads sorted levels 0..upto-1 (with some flat steps) and rising borders 0..upto.
  function automatic void load_sorted(int unsigned n, int unsigned upto);
    int unsigned acc;
    int b;
    acc = 0;
    for (int unsigned i = 0; i < upto; i++) begin
      if (i < n - 1 && $urandom_range(0, 7) != 0) acc += $urandom_range(0, 2 * OneQ24 / upto);
      if (acc >= OneQ24) acc = OneQ24 - 1;
      // A partial load ends with a level of 1.0 so that no draw scans past it.
      if (upto < n && i == upto - 1) acc = OneQ24;
      push_word(ics_pkg::OpWrLevel, i, {$urandom, 25'd0} | acc, $urandom);
    end
    b = -int'($urandom_range(0, 1 << 24));
    for (int unsigned i = 0; i <= upto && i <= ics_pkg::TableDepth; i++) begin
      push_word(ics_pkg::OpWrBorder, i, b, $urandom);
      b += int'($urandom_range(0, 1 << 18));
    end
  endfunction

  function automatic void random_word(int unsigned n, int unsigned lim);
    int unsigned r, i;
    logic [24:0] p;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      case ($urandom_range(0, 9))
        0: p = $urandom_range(OneQ24, 33554431);
        1, 2: begin
          i = $urandom_range(0, lim - 1);
          p = level_m[i] + $urandom_range(0, 2) - 1;
        end
        default: p = $urandom_range(0, OneQ24 - 1);
      endcase
      // With only part of the table loaded, draws stay below the top written level.
      if (lim < n && p >= OneQ24) p = OneQ24 - 1;
      push_word(ics_pkg::OpDraw, $urandom, $urandom, p);
    end else if (r < 80) begin
      push_word(ics_pkg::OpWrBorder, $urandom_range(0, 8) == 0 ? $urandom_range(0, 2047)
                : $urandom_range(0, n), $urandom, $urandom);
    end else if (r < 92) begin
      i = ($urandom_range(0, 8) == 0) ? $urandom_range(0, 2047)
          : $urandom_range(0, ics_pkg::TableDepth - 1);
      // The top written level keeps its value while the table is only partly loaded.
      if (lim < n && i == lim - 1) i = 0;
      push_word(ics_pkg::OpWrLevel, i, $urandom, $urandom);
    end else begin
      push_word(OpUnused, $urandom, $urandom, $urandom);
    end
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || start || busy || draws_q.size() != 0);
    repeat (1300) @(posedge clk_i);
  endtask

  task automatic set_bins(logic [10:0] v);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bins_m = v;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned settings[8];
    int unsigned n, lim, count;
    settings = '{2, 3, 0, 17, 2047, 64, 1, 1024};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Edge cases run on a small table that is fully written before any draw.
    set_bins(11'd8);
    load_sorted(8, 8);
    push_word(ics_pkg::OpDraw, 0, 0, 25'd0);
    push_word(ics_pkg::OpDraw, 0, 0, OneQ24);
    push_word(ics_pkg::OpDraw, 0, 0, 25'h1FF_FFFF);
    push_word(ics_pkg::OpDraw, 0, 0, OneQ24 - 1);
    push_word(OpUnused, 11'h7FF, 32'hFFFF_FFFF, 25'h1FF_FFFF);
    push_word(ics_pkg::OpWrLevel, ics_pkg::TableDepth, 0, 0);
    push_word(ics_pkg::OpWrBorder, ics_pkg::TableDepth + 1, 32'h7FFF_FFFF, 0);
    push_word(ics_pkg::OpWrBorder, 2047, 0, 0);
    push_word(ics_pkg::OpWrLevel, 0, 32'h01FF_FFFF, 0);
    push_word(ics_pkg::OpDraw, 0, 0, 25'd5);
    push_word(ics_pkg::OpWrBorder, 1, 32'h7FFF_FFFF, 0);
    push_word(ics_pkg::OpWrBorder, 0, 32'h8000_0000, 0);
    push_word(ics_pkg::OpDraw, 0, 0, 25'd7);
    push_word(ics_pkg::OpWrLevel, 0, 32'd0, 0);
    push_word(ics_pkg::OpDraw, 0, 0, 25'd100);
    wait_idle();
    foreach (settings[s]) begin
      set_bins(settings[s]);
      n = (bins_m < 2) ? 2 : (bins_m > ics_pkg::TableDepth) ? ics_pkg::TableDepth : bins_m;
      // Large tables are loaded only in part; draws then stay inside the loaded bins.
      lim = (n > 64) ? 40 : n;
      load_sorted(n, lim);
      count = 85;
      if (s == 7) no_gaps = 1'b1;
      for (int unsigned j = 0; j < count; j++) random_word(n, lim);
      wait_idle();
    end
    $display("accepted %0d words, checked %0d draws (%0d flat) over 9 bin settings",
             n_words, n_draws, n_flat);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
